// ===== hdl/glti_pkg.sv =====
`default_nettype none
package glti_pkg;

	localparam int GRID_CELLS  = 64;
	localparam int LEVEL_COUNT = 4;

	localparam int LEVEL_W = 2;
	localparam int TRI_W   = 14;
	localparam int VERT_W  = 13;

	localparam int LEVELS = 1 << LEVEL_W;

	// Vertices per grid row, grid vertex count, and base of the bottom grid row.
	localparam int GRID_ROW    = GRID_CELLS + 1;
	localparam int GRID_VERTS  = GRID_ROW * GRID_ROW;
	localparam int BOTTOM_BASE = GRID_VERTS - GRID_ROW;

	// Internal index width covers the grid plus the four skirt rows.
	localparam int IDX_W = $clog2(GRID_ROW * (GRID_ROW + 4));

	// The triangle number scaled by the stride, and its split into list rows.
	// Each list row holds 2n triangles, so row = (t * s) / (2 * GRID_CELLS).
	localparam int XW        = TRI_W + LEVELS - 1;
	localparam int ROW_DIV   = 2 * GRID_CELLS;
	localparam int PROD_W    = 2 * XW;
	localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / ROW_DIV);

	localparam int ROW_W = $clog2(GRID_CELLS + 4);
	localparam int REM_W = $clog2(2 * GRID_CELLS);

	function automatic logic [LEVELS-1:0] level_ok_mask();
		logic [LEVELS-1:0] m;
		m = '0;
		for (int i = 0; i < LEVELS; i++) begin
			m[i] = (i < LEVEL_COUNT) && ((1 << i) <= GRID_CELLS) &&
				((GRID_CELLS & ((1 << i) - 1)) == 0);
		end
		return m;
	endfunction

	localparam logic [LEVELS-1:0] LEVEL_OK = level_ok_mask();

	typedef enum logic [1:0] {
		STRIP_TOP    = 2'd0,
		STRIP_RIGHT  = 2'd1,
		STRIP_BOTTOM = 2'd2,
		STRIP_LEFT   = 2'd3
	} glti_strip_t;

	// Result of the row split, handed from the divider stages to the vertex stages.
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               in_range;
		logic [ROW_W-1:0]   row;
		logic [REM_W-1:0]   rem;
	} glti_split_t;

endpackage
`default_nettype wire

// ===== hdl/glti_if.sv =====
`default_nettype none
interface glti_in_if;
	import glti_pkg::*;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] detail_level;
	logic [TRI_W-1:0]   triangle_number;

	modport source (output valid, output detail_level, output triangle_number, input ready);
	modport sink (input valid, input detail_level, input triangle_number, output ready);
endinterface

interface glti_out_if;
	import glti_pkg::*;
	logic              valid;
	logic              ready;
	logic [VERT_W-1:0] vertex_a;
	logic [VERT_W-1:0] vertex_b;
	logic [VERT_W-1:0] vertex_c;
	logic              in_range;

	modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
		output in_range, input ready);
	modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
		input in_range, output ready);
endinterface
`default_nettype wire

// ===== hdl/glti_row_split.sv =====
`default_nettype none
module glti_row_split
	import glti_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	glti_in_if.sink      tri_in,
	output glti_split_t  split,
	output logic         split_valid,
	input  wire logic    split_ready
);

	logic              v_s1, v_s2;
	logic              adv_s1, adv_s2;
	logic [LEVEL_W-1:0] level_s1;
	logic              ok_s1;
	logic [XW-1:0]     x_s1;
	logic [PROD_W-1:0] prod_s1;
	glti_split_t       split_s2;

	logic [XW-1:0]     x_c;
	logic [XW-1:0]     q_est, q_fix;
	logic [XW-1:0]     rem_est, rem_fix;
	logic [XW-1:0]     rows_total;

	assign adv_s2 = !v_s2 || split_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign tri_in.ready = adv_s1;

	assign x_c = XW'(tri_in.triangle_number) << tri_in.detail_level;

	// The reciprocal estimate is at most one low; one compare and subtract fixes it.
	always_comb begin
		q_est   = prod_s1[PROD_W-1:XW];
		rem_est = x_s1 - XW'(q_est * XW'(ROW_DIV));
		if (rem_est >= XW'(ROW_DIV)) begin
			q_fix   = q_est + XW'(1);
			rem_fix = rem_est - XW'(ROW_DIV);
		end else begin
			q_fix   = q_est;
			rem_fix = rem_est;
		end
		rows_total = XW'(GRID_CELLS >> level_s1) + XW'(4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= tri_in.valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			level_s1 <= tri_in.detail_level;
			ok_s1    <= LEVEL_OK[tri_in.detail_level];
			x_s1     <= x_c;
			prod_s1  <= PROD_W'(x_c) * PROD_W'(RECIP);
		end
		if (adv_s2) begin
			split_s2.level    <= level_s1;
			split_s2.in_range <= ok_s1 && (q_fix < rows_total);
			split_s2.row      <= ROW_W'(q_fix);
			split_s2.rem      <= REM_W'(rem_fix);
		end
	end

	assign split       = split_s2;
	assign split_valid = v_s2;

endmodule
`default_nettype wire

// ===== hdl/glti_vertex_calc.sv =====
`default_nettype none
module glti_vertex_calc
	import glti_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire glti_split_t  split,
	input  wire logic         split_valid,
	output logic              split_ready,
	glti_out_if.source        tri_out
);

	typedef struct packed {
		logic             in_range;
		logic             mesh;
		logic             second;
		glti_strip_t      strip;
		logic [IDX_W-1:0] zr;
		logic [IDX_W-1:0] xe;
		logic [IDX_W-1:0] xo;
		logic [IDX_W-1:0] pr;
		logic [IDX_W-1:0] sr;
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] f;
	} glti_terms_t;

	logic        v_s3, v_s4;
	logic        adv_s3, adv_s4;
	glti_terms_t terms_c, terms_s3;

	logic [REM_W-1:0] u;
	logic [REM_W:0]   uo;
	logic [ROW_W-1:0] n_rows;

	logic [IDX_W-1:0] a_c, b_c, c_c;
	logic [IDX_W-1:0] cur, nxt, fp, fps, psr;

	logic [VERT_W-1:0] a_s4, b_s4, c_s4;
	logic              in_range_s4;

	assign adv_s4 = !v_s4 || tri_out.ready;
	assign adv_s3 = !v_s3 || adv_s4;
	assign split_ready = adv_s3;

	always_comb begin
		u      = split.rem >> split.level;
		uo     = ({1'b0, u} + (REM_W+1)'(1)) >> 1;
		n_rows = ROW_W'(GRID_CELLS >> split.level);

		terms_c.in_range = split.in_range;
		terms_c.mesh     = split.row < n_rows;
		terms_c.second   = u[0];
		terms_c.strip    = glti_strip_t'(2'(split.row - n_rows));
		terms_c.xe       = IDX_W'(u >> 1) << split.level;
		terms_c.xo       = IDX_W'(uo) << split.level;
		terms_c.zr       = IDX_W'((IDX_W'(split.row) << split.level) * IDX_W'(GRID_ROW));
		terms_c.pr       = IDX_W'(terms_c.xe * IDX_W'(GRID_ROW));
		terms_c.sr       = IDX_W'(GRID_ROW) << split.level;
		terms_c.s        = IDX_W'(1) << split.level;
		terms_c.f        = IDX_W'(GRID_VERTS) + IDX_W'(IDX_W'(terms_c.strip) *
			IDX_W'(GRID_ROW));
	end

	always_comb begin
		// For skirts the step position p equals the even-column x offset.
		fp  = terms_s3.f + terms_s3.xe;
		fps = fp + terms_s3.s;
		psr = terms_s3.pr + terms_s3.sr;
		cur = terms_s3.second ? terms_s3.zr + terms_s3.xo : terms_s3.zr + terms_s3.xe;
		nxt = cur + terms_s3.sr;
		a_c = '0;
		b_c = '0;
		c_c = '0;
		if (!terms_s3.in_range) begin
			a_c = '0;
		end else if (terms_s3.mesh) begin
			a_c = cur;
			if (terms_s3.second) begin
				b_c = nxt - terms_s3.s;
				c_c = nxt;
			end else begin
				b_c = nxt;
				c_c = cur + terms_s3.s;
			end
		end else begin
			case (terms_s3.strip)
				STRIP_TOP: begin
					a_c = terms_s3.xe;
					if (terms_s3.second) begin
						b_c = terms_s3.xe + terms_s3.s;
						c_c = fps;
					end else begin
						b_c = fps;
						c_c = fp;
					end
				end
				STRIP_RIGHT: begin
					if (terms_s3.second) begin
						a_c = fp;
						b_c = terms_s3.pr + IDX_W'(GRID_CELLS);
						c_c = psr + IDX_W'(GRID_CELLS);
					end else begin
						a_c = psr + IDX_W'(GRID_CELLS);
						b_c = fps;
						c_c = fp;
					end
				end
				STRIP_BOTTOM: begin
					b_c = fp;
					if (terms_s3.second) begin
						a_c = IDX_W'(BOTTOM_BASE) + terms_s3.xe;
						c_c = IDX_W'(BOTTOM_BASE) + terms_s3.xe + terms_s3.s;
					end else begin
						a_c = IDX_W'(BOTTOM_BASE) + terms_s3.xe + terms_s3.s;
						c_c = fps;
					end
				end
				STRIP_LEFT: begin
					b_c = fp;
					if (terms_s3.second) begin
						a_c = terms_s3.pr;
						c_c = psr;
					end else begin
						a_c = psr;
						c_c = fps;
					end
				end
				default: begin
					a_c = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s3) v_s3 <= split_valid;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) terms_s3 <= terms_c;
		if (adv_s4) begin
			a_s4        <= VERT_W'(a_c);
			b_s4        <= VERT_W'(b_c);
			c_s4        <= VERT_W'(c_c);
			in_range_s4 <= terms_s3.in_range;
		end
	end

	assign tri_out.valid    = v_s4;
	assign tri_out.vertex_a = a_s4;
	assign tri_out.vertex_b = b_s4;
	assign tri_out.vertex_c = c_s4;
	assign tri_out.in_range = in_range_s4;

endmodule
`default_nettype wire

// ===== hdl/grid_lod_triangle_index_generator.sv =====
// Terrain grid triangle index generator with edge skirts.
// The tri_in channel carries one transaction per triangle: a detail level
// and the triangle's number in that level's index list. The tri_out channel
// returns, per transaction, the three vertex indices and an in_range flag;
// numbers past the level's list, or levels without triangles, give zeros
// with in_range low.
// Four register stages: stage one scales the number by the stride and
// multiplies by a reciprocal, stage two finishes the split into list row
// and column, stage three forms the row and step products, stage four adds
// and selects. A result moves through the stages in that order and shows on
// tri_out once stage four holds it; one transaction is taken every clock
// while tri_out does not stall.
// Reset clears only the stage valid bits; the pipeline is empty afterwards.
// When tri_out stalls, the stages fill their empty slots and then hold;
// tri_in.ready drops only once all four stages are occupied.
`default_nettype none
module grid_lod_triangle_index_generator
	import glti_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	glti_in_if.sink    tri_in,
	glti_out_if.source tri_out
);

	glti_split_t split;
	logic        split_valid;
	logic        split_ready;

	glti_row_split u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.tri_in      (tri_in),
		.split       (split),
		.split_valid (split_valid),
		.split_ready (split_ready)
	);

	glti_vertex_calc u_vertex (
		.clk         (clk),
		.arst_n      (arst_n),
		.split       (split),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.tri_out     (tri_out)
	);

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	import glti_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RANDOM_ITEMS   = 530;
	localparam int IDLE_PCT       = 33;

	typedef struct packed {
		logic [VERT_W-1:0] a;
		logic [VERT_W-1:0] b;
		logic [VERT_W-1:0] c;
		logic              in_range;
	} tri_vertices_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [TRI_W-1:0]   num;
		logic               literal;
		tri_vertices_t      want;
	} stim_row_t;

	localparam tri_vertices_t NO_TRIANGLE = '{13'd0, 13'd0, 13'd0, 1'b0};
	localparam tri_vertices_t UNTYPED     = '{13'd0, 13'd0, 13'd0, 1'b0};

	// Rows with literal set carry the expected vertices typed in; the rest
	// go through the predictor.
	localparam int DIRECTED_ROWS = 25;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{2'd0, 14'd0,     1'b1, '{13'd0,    13'd65,   13'd1,    1'b1}},
		'{2'd0, 14'd1,     1'b1, '{13'd1,    13'd65,   13'd66,   1'b1}},
		'{2'd0, 14'd127,   1'b0, UNTYPED},
		'{2'd0, 14'd128,   1'b0, UNTYPED},
		'{2'd0, 14'd8191,  1'b0, UNTYPED},
		'{2'd0, 14'd8192,  1'b0, UNTYPED},
		'{2'd0, 14'd8193,  1'b0, UNTYPED},
		'{2'd0, 14'd8320,  1'b0, UNTYPED},
		'{2'd0, 14'd8321,  1'b0, UNTYPED},
		'{2'd0, 14'd8448,  1'b0, UNTYPED},
		'{2'd0, 14'd8449,  1'b0, UNTYPED},
		'{2'd0, 14'd8576,  1'b0, UNTYPED},
		'{2'd0, 14'd8703,  1'b1, '{13'd4095, 13'd4483, 13'd4160, 1'b1}},
		'{2'd0, 14'd8704,  1'b1, NO_TRIANGLE},
		'{2'd0, 14'd16383, 1'b1, NO_TRIANGLE},
		'{2'd1, 14'd0,     1'b0, UNTYPED},
		'{2'd1, 14'd2303,  1'b0, UNTYPED},
		'{2'd1, 14'd2304,  1'b1, NO_TRIANGLE},
		'{2'd2, 14'd600,   1'b0, UNTYPED},
		'{2'd2, 14'd640,   1'b1, NO_TRIANGLE},
		'{2'd3, 14'd0,     1'b0, UNTYPED},
		'{2'd3, 14'd191,   1'b1, '{13'd3640, 13'd4476, 13'd4160, 1'b1}},
		'{2'd3, 14'd192,   1'b1, NO_TRIANGLE},
		'{2'd3, 14'd8191,  1'b1, NO_TRIANGLE},
		'{2'd2, 14'd8192,  1'b1, NO_TRIANGLE}
	};

	logic clk;
	logic arst_n;

	glti_in_if  in_ch ();
	glti_out_if out_ch ();

	grid_lod_triangle_index_generator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.tri_in  (in_ch),
		.tri_out (out_ch)
	);

	tri_vertices_t expected_tris [$];
	tri_vertices_t pending_tri;
	int            error_count;
	int            quiet_cycles;
	bit            no_gaps;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic tri_vertices_t vertices(int unsigned a, int unsigned b, int unsigned c);
		tri_vertices_t v;
		v.a        = a[VERT_W-1:0];
		v.b        = b[VERT_W-1:0];
		v.c        = c[VERT_W-1:0];
		v.in_range = 1'b1;
		return v;
	endfunction

	function automatic int unsigned list_length(logic [LEVEL_W-1:0] level);
		int unsigned s;
		int unsigned n;
		s = 1 << level;
		if (level >= LEVEL_COUNT || s > GRID_CELLS || (GRID_CELLS % s) != 0) begin
			return 0;
		end
		n = GRID_CELLS / s;
		return 2 * n * n + 8 * n;
	endfunction

	function automatic tri_vertices_t triangle_vertices(logic [LEVEL_W-1:0] level,
		logic [TRI_W-1:0] num);
		int unsigned m, r, g, s, n, mesh, t;
		int unsigned row, u, z, x, cur, nxt;
		int unsigned k, strip, rem, p, f, b;
		logic second;
		m = GRID_CELLS;
		r = m + 1;
		g = r * r;
		s = 1 << level;
		t = num;
		if (t >= list_length(level)) begin
			return NO_TRIANGLE;
		end
		n = m / s;
		mesh = 2 * n * n;
		if (t < mesh) begin
			row = t / (2 * n);
			u = t % (2 * n);
			z = row * s;
			if (u[0] == 1'b0) begin
				x = (u / 2) * s;
				cur = z * r + x;
				nxt = (z + s) * r + x;
				return vertices(cur, nxt, cur + s);
			end
			x = ((u + 1) / 2) * s;
			cur = z * r + x;
			nxt = (z + s) * r + x;
			return vertices(cur, nxt - s, nxt);
		end
		k = t - mesh;
		strip = k / (2 * n);
		rem = k % (2 * n);
		p = (rem / 2) * s;
		second = rem[0];
		f = g + strip * r;
		b = g - r;
		case (strip)
			STRIP_TOP: begin
				return second ? vertices(p, p + s, f + p + s) : vertices(p, f + p + s, f + p);
			end
			STRIP_RIGHT: begin
				return second ? vertices(f + p, p * r + m, (p + s) * r + m)
					: vertices((p + s) * r + m, f + p + s, f + p);
			end
			STRIP_BOTTOM: begin
				return second ? vertices(b + p, f + p, b + p + s)
					: vertices(b + p + s, f + p, f + p + s);
			end
			default: begin
				return second ? vertices(p * r, f + p, (p + s) * r)
					: vertices((p + s) * r, f + p, f + p + s);
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_triangle(logic [LEVEL_W-1:0] level, logic [TRI_W-1:0] num,
		tri_vertices_t want);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pending_tri = want;
		in_ch.valid <= 1'b1;
		in_ch.detail_level <= level;
		in_ch.triangle_number <= num;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
	end

	// The expectation is queued when the input transaction is seen, so that
	// the sender's bookkeeping never races the result checks.
	always @(posedge clk) begin
		tri_vertices_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_tris = {expected_tris, pending_tri};
				moved = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				if (expected_tris.size() == 0) begin
					report_mismatch("result transaction with no triangle outstanding");
				end else begin
					want = expected_tris.pop_front();
					if (out_ch.vertex_a !== want.a)
						report_mismatch($sformatf("vertex_a got %0d want %0d",
							out_ch.vertex_a, want.a));
					if (out_ch.vertex_b !== want.b)
						report_mismatch($sformatf("vertex_b got %0d want %0d",
							out_ch.vertex_b, want.b));
					if (out_ch.vertex_c !== want.c)
						report_mismatch($sformatf("vertex_c got %0d want %0d",
							out_ch.vertex_c, want.c));
					if (out_ch.in_range !== want.in_range)
						report_mismatch($sformatf("in_range got %0d want %0d",
							out_ch.in_range, want.in_range));
				end
			end
		end
		if (moved) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [LEVEL_W-1:0] level;
		logic [TRI_W-1:0]   num;
		int unsigned        total;
		int unsigned        mesh;
		int unsigned        n;
		int unsigned        pick;
		error_count = 0;
		quiet_cycles = 0;
		no_gaps = 1'b0;
		pending_tri = NO_TRIANGLE;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.detail_level = '0;
		in_ch.triangle_number = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_triangle(DIRECTED[i].level, DIRECTED[i].num,
				DIRECTED[i].literal ? DIRECTED[i].want
				: triangle_vertices(DIRECTED[i].level, DIRECTED[i].num));
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_gaps = (i >= 150 && i < 300);
			if (i == 400) begin
				// Let the pipeline run dry before the next transaction.
				in_ch.valid <= 1'b0;
				while (expected_tris.size() != 0) @(negedge clk);
				@(negedge clk);
			end
			level = LEVEL_W'($urandom_range(LEVELS - 1));
			total = list_length(level);
			n = GRID_CELLS >> level;
			mesh = 2 * n * n;
			pick = $urandom_range(99);
			if (pick < 60) begin
				num = TRI_W'($urandom_range(mesh - 1));
			end else if (pick < 85) begin
				num = TRI_W'($urandom_range(total - 1, mesh));
			end else if (pick < 92) begin
				num = TRI_W'($urandom_range(total + 1, total - 2));
			end else begin
				num = TRI_W'($urandom_range((1 << TRI_W) - 1));
			end
			send_triangle(level, num, triangle_vertices(level, num));
		end
		in_ch.valid <= 1'b0;
		no_gaps = 1'b0;

		while (expected_tris.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
